// ===== rtl/hrws_pkg.sv =====
// Shared types, widths and constants of the heart-rate window smoother.
package hrws_pkg;

    localparam int TIME_BITS  = 32;
    localparam int COUNT_BITS = 10;
    localparam int SUM_BITS   = 18;
    localparam int RATE_BITS  = 16;   // Q8.8 smoothed rate
    localparam int BPM_BITS   = 8;
    localparam int ALPHA_BITS = 9;
    localparam int BEATS_BITS = 10;

    localparam int SUM_MAX    = (1 << SUM_BITS) - 1;
    localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;
    localparam int MS_PER_MIN = 60000;
    localparam int Q8_ONE     = 256;

    // shared divider: dividend is 60000 or the window sum in Q.8, divisor the interval or count
    localparam int DIV_NW = SUM_BITS + 8;
    localparam int DIV_DW = (TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // shared multiplier; only the low ACC_BITS of the EMA sum reach the result
    localparam int ACC_BITS = 24;
    localparam int MUL_AW   = (TIME_BITS > ACC_BITS) ? TIME_BITS : ACC_BITS;
    localparam int MUL_BW   = ALPHA_BITS;
    localparam int MUL_PW   = MUL_AW + MUL_BW;

    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 32;

    localparam logic [1:0] KIND_BEAT   = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_MIN   = 2'd1;
    localparam logic [1:0] REG_MAX   = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] time_ms;
    } t_in;

    typedef struct packed {
        logic [BPM_BITS-1:0]   rate_bpm;
        logic [BEATS_BITS-1:0] window_beats;
        logic                  window_used;
    } t_out;

    typedef struct packed {
        logic [ALPHA_BITS-1:0] alpha_q8;
        logic [BPM_BITS-1:0]   min_bpm;
        logic [BPM_BITS-1:0]   max_bpm;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/hrws_div.sv =====
// Restoring divider, one quotient bit per cycle.
module hrws_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hrws_pkg::t_div_req i_req,
    output hrws_pkg::t_div_rsp o_rsp
);

    logic [hrws_pkg::DIV_DW-1:0] r_rem;
    logic [hrws_pkg::DIV_DW-1:0] r_dsr;
    logic [hrws_pkg::DIV_NW-1:0] r_quot;
    logic [hrws_pkg::DIV_CW-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [hrws_pkg::DIV_DW:0]   rem_sh;
    logic [hrws_pkg::DIV_DW+1:0] diff;
    logic                        q_bit;

    always_comb begin
        rem_sh = {r_rem, r_quot[hrws_pkg::DIV_NW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dsr};
        q_bit  = ~diff[hrws_pkg::DIV_DW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= hrws_pkg::DIV_CW'(hrws_pkg::DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == hrws_pkg::DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_dsr  <= i_req.divisor;
            r_quot <= i_req.dividend;
        end else if (r_busy) begin
            r_rem  <= q_bit ? diff[hrws_pkg::DIV_DW-1:0] : rem_sh[hrws_pkg::DIV_DW-1:0];
            r_quot <= {r_quot[hrws_pkg::DIV_NW-2:0], q_bit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== rtl/hrws_apb_regs.sv =====
// APB configuration registers: alpha, minimum and maximum rate.
module hrws_apb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hrws_pkg::PADDR_BITS-1:0] paddr,
    input  logic [hrws_pkg::PDATA_BITS-1:0] pwdata,
    output logic [hrws_pkg::PDATA_BITS-1:0] prdata,
    output logic                            pready,
    output hrws_pkg::t_cfg                  o_cfg
);

    hrws_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha_q8 <= hrws_pkg::ALPHA_BITS'(77);
            r_cfg.min_bpm  <= hrws_pkg::BPM_BITS'(20);
            r_cfg.max_bpm  <= hrws_pkg::BPM_BITS'(255);
        end else if (wr_en) begin
            unique case (reg_idx)
                hrws_pkg::REG_ALPHA: r_cfg.alpha_q8 <= pwdata[hrws_pkg::ALPHA_BITS-1:0];
                hrws_pkg::REG_MIN:   r_cfg.min_bpm  <= pwdata[hrws_pkg::BPM_BITS-1:0];
                hrws_pkg::REG_MAX:   r_cfg.max_bpm  <= pwdata[hrws_pkg::BPM_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            hrws_pkg::REG_ALPHA: prdata = hrws_pkg::PDATA_BITS'(r_cfg.alpha_q8);
            hrws_pkg::REG_MIN:   prdata = hrws_pkg::PDATA_BITS'(r_cfg.min_bpm);
            hrws_pkg::REG_MAX:   prdata = hrws_pkg::PDATA_BITS'(r_cfg.max_bpm);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/heart_rate_window_smoother.sv =====
// Top level of the heart-rate window smoother: sequencer, state and shared multiplier.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one beat per
// item: a beat event with its ms timestamp, a report tick or a clear.
// Output channel (o_out_valid / i_out_ready / o_out_data) carries one beat
// per report tick: smoothed rate, beats in the closed window, window used.
// Configuration: APB registers alpha_q8 (0x0), min_bpm (0x4), max_bpm (0x8).
//
// One item at a time. A beat event whose interval passes the range check
// uses the shared 32x9 multiplier for the low and high checks, then the
// shared restoring divider for 60000/interval, updates the window as the
// divider finishes and goes back to idle; a beat that fails the check
// returns to idle straight after the high check. A report tick with beats
// has the divider form the Q8.8 window mean and the multiplier the two EMA
// products (skipped when it seeds the average), then goes to the output state.
// An empty window reports straight away; clear and the unused kind stay in idle.
// A finished result sits in the output register; the block goes on taking
// items while it waits. Only a second report stalls behind an untaken one.
// Reset (synchronous, active low) empties the window, zeroes the average,
// held rate and last timestamp, and loads the register defaults.
module heart_rate_window_smoother (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  hrws_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output hrws_pkg::t_out                  o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hrws_pkg::PADDR_BITS-1:0] paddr,
    input  logic [hrws_pkg::PDATA_BITS-1:0] pwdata,
    output logic [hrws_pkg::PDATA_BITS-1:0] prdata,
    output logic                            pready
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
    localparam logic [2:0] S_LO   = 3'd1;  // min_bpm * interval < 60000 ?
    localparam logic [2:0] S_HI   = 3'd2;  // max_bpm * interval > 60000 ?
    localparam logic [2:0] S_BDIV = 3'd3;  // 60000 / interval
    localparam logic [2:0] S_RDIV = 3'd4;  // window mean
    localparam logic [2:0] S_M1   = 3'd5;  // mean * alpha
    localparam logic [2:0] S_M2   = 3'd6;  // + old * (1 - alpha)
    localparam logic [2:0] S_OUT  = 3'd7;  // hand result to output register

    hrws_pkg::t_cfg     cfg;
    hrws_pkg::t_div_req div_req;
    hrws_pkg::t_div_rsp div_rsp;

    logic [2:0]                      r_state;
    logic [2:0]                      n_state;
    logic [hrws_pkg::TIME_BITS-1:0]  r_last;
    logic [hrws_pkg::TIME_BITS-1:0]  r_delta;
    logic [hrws_pkg::SUM_BITS-1:0]   r_sum;
    logic [hrws_pkg::COUNT_BITS-1:0] r_count;
    logic [hrws_pkg::RATE_BITS-1:0]  r_smooth;
    logic [hrws_pkg::BPM_BITS-1:0]   r_held;
    logic                            r_lo_ok;
    logic [hrws_pkg::ACC_BITS-1:0]   r_mean;
    logic [hrws_pkg::ACC_BITS-1:0]   r_acc;
    hrws_pkg::t_out                  r_res;
    hrws_pkg::t_out                  r_out_data;
    logic                            r_out_valid;

    logic                            in_fire;
    logic                            out_free;
    logic [hrws_pkg::TIME_BITS-1:0]  now_t;
    logic [hrws_pkg::ALPHA_BITS-1:0] alpha_sat;
    logic [hrws_pkg::ALPHA_BITS-1:0] alpha_inv;
    logic [hrws_pkg::MUL_AW-1:0]     mul_a;
    logic [hrws_pkg::MUL_BW-1:0]     mul_b;
    logic [hrws_pkg::MUL_PW-1:0]     mul_p;
    logic [hrws_pkg::ACC_BITS-1:0]   acc_sum;
    logic [hrws_pkg::DIV_NW:0]       sum_try;
    logic                            beat_fits;

    hrws_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hrws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid & o_in_ready;
    assign out_free   = ~r_out_valid | i_out_ready;
    assign now_t      = i_in_data.time_ms[hrws_pkg::TIME_BITS-1:0];

    // alpha above one acts as one
    assign alpha_sat = (cfg.alpha_q8 > hrws_pkg::ALPHA_BITS'(hrws_pkg::Q8_ONE)) ?
                       hrws_pkg::ALPHA_BITS'(hrws_pkg::Q8_ONE) : cfg.alpha_q8;
    assign alpha_inv = hrws_pkg::ALPHA_BITS'(hrws_pkg::Q8_ONE) - alpha_sat;

    // the one shared multiplier; operands picked by the sequencer
    always_comb begin
        unique case (r_state)
            S_LO: begin
                mul_a = hrws_pkg::MUL_AW'(r_delta);
                mul_b = hrws_pkg::MUL_BW'(cfg.min_bpm);
            end
            S_HI: begin
                mul_a = hrws_pkg::MUL_AW'(r_delta);
                mul_b = hrws_pkg::MUL_BW'(cfg.max_bpm);
            end
            S_M1: begin
                mul_a = hrws_pkg::MUL_AW'(r_mean);
                mul_b = alpha_sat;
            end
            default: begin
                mul_a = hrws_pkg::MUL_AW'(r_smooth);
                mul_b = alpha_inv;
            end
        endcase
        mul_p = hrws_pkg::MUL_PW'(mul_a) * hrws_pkg::MUL_PW'(mul_b);
    end

    // EMA sum kept modulo 2^24: bits above never reach the 16-bit result
    assign acc_sum = r_acc + mul_p[hrws_pkg::ACC_BITS-1:0];

    // window overflow check for the beat value just divided out
    assign sum_try   = (hrws_pkg::DIV_NW+1)'(r_sum) + (hrws_pkg::DIV_NW+1)'(div_rsp.quot);
    assign beat_fits = (sum_try <= (hrws_pkg::DIV_NW+1)'(hrws_pkg::SUM_MAX)) &&
                       (r_count != hrws_pkg::COUNT_BITS'(hrws_pkg::COUNT_MAX));

    // divider launch: interval after the range check, mean on a non-empty report
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = hrws_pkg::DIV_NW'(hrws_pkg::MS_PER_MIN);
        div_req.divisor  = hrws_pkg::DIV_DW'(r_delta);
        if (r_state == S_HI) begin
            div_req.start = r_lo_ok &&
                            (mul_p > hrws_pkg::MUL_PW'(hrws_pkg::MS_PER_MIN));
        end else if (in_fire && (i_in_data.kind == hrws_pkg::KIND_REPORT)) begin
            div_req.start    = (r_count != '0);
            div_req.dividend = {r_sum, 8'h00};
            div_req.divisor  = hrws_pkg::DIV_DW'(r_count);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    priority if (i_in_data.kind == hrws_pkg::KIND_BEAT) begin
                        n_state = S_LO;
                    end else if (i_in_data.kind == hrws_pkg::KIND_REPORT) begin
                        n_state = (r_count != '0) ? S_RDIV : S_OUT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LO:   n_state = S_HI;
            S_HI:   n_state = div_req.start ? S_BDIV : S_IDLE;
            S_BDIV: n_state = div_rsp.done ? S_IDLE : S_BDIV;
            S_RDIV: begin
                if (div_rsp.done) begin
                    n_state = (r_smooth == '0) ? S_OUT : S_M1;
                end
            end
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_OUT;
            S_OUT:  n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_smooth    <= '0;
            r_held      <= '0;
        end else begin
            r_state <= n_state;

            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in_data.kind == hrws_pkg::KIND_BEAT) begin
                            r_last <= now_t;   // timestamp taken whether valid or not
                        end else if (i_in_data.kind == hrws_pkg::KIND_REPORT) begin
                            r_sum   <= '0;     // divider has latched sum and count
                            r_count <= '0;
                        end else if (i_in_data.kind == hrws_pkg::KIND_CLEAR) begin
                            r_sum    <= '0;
                            r_count  <= '0;
                            r_smooth <= '0;
                        end
                    end
                end
                S_BDIV: begin
                    if (div_rsp.done && beat_fits) begin
                        r_sum   <= sum_try[hrws_pkg::SUM_BITS-1:0];
                        r_count <= r_count + 1'b1;
                    end
                end
                S_RDIV: begin
                    // a zero average (after reset or clear) is seeded from the window mean
                    if (div_rsp.done && (r_smooth == '0)) begin
                        r_smooth <= div_rsp.quot[hrws_pkg::RATE_BITS-1:0];
                        r_held   <= div_rsp.quot[hrws_pkg::RATE_BITS-1:8];
                    end
                end
                S_M2: begin
                    r_smooth <= acc_sum[hrws_pkg::ACC_BITS-1:8];
                    r_held   <= acc_sum[hrws_pkg::ACC_BITS-1:16];
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_delta                <= now_t - r_last;
                    r_res.window_beats     <= hrws_pkg::BEATS_BITS'(r_count);
                    r_res.window_used      <= (r_count != '0);
                    // empty window: report the average as it stands, or the held rate when it is zero
                    r_res.rate_bpm         <= (r_smooth != '0) ? r_smooth[15:8] : r_held;
                end
            end
            S_LO: begin
                r_lo_ok <= (mul_p < hrws_pkg::MUL_PW'(hrws_pkg::MS_PER_MIN));
            end
            S_RDIV: begin
                if (div_rsp.done) begin
                    r_mean         <= div_rsp.quot[hrws_pkg::ACC_BITS-1:0];
                    r_res.rate_bpm <= div_rsp.quot[hrws_pkg::RATE_BITS-1:8];
                end
            end
            S_M1: begin
                r_acc <= mul_p[hrws_pkg::ACC_BITS-1:0];
            end
            S_M2: begin
                r_res.rate_bpm <= acc_sum[hrws_pkg::ACC_BITS-1:16];
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_data <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/hrws_checker.sv =====
// Port-level checks on the heart-rate window smoother, bound to the top level.
module hrws_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input hrws_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input hrws_pkg::t_out o_out_data
);

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // beats and reports drop ready in the cycle after they are taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready &&
        (i_in_data.kind == hrws_pkg::KIND_BEAT || i_in_data.kind == hrws_pkg::KIND_REPORT)
        |=> !o_in_ready)
        else $error("ready straight after beat or report");

    // an unused window counted no beats
    a_unused_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.window_used |-> o_out_data.window_beats == '0)
        else $error("unused window with beats");

endmodule

bind heart_rate_window_smoother hrws_checker u_hrws_checker (.*);
